### src/bbrr_pkg.sv
`default_nettype none
package bbrr_pkg;

	// default geometry
	localparam int BUCKETS_DEF      = 129;
	localparam int BUCKET_DEPTH_DEF = 16;

	// fixed field widths
	localparam int BKT_IDX_W   = 8;
	localparam int TOTAL_W     = 12;
	localparam int MAX_TOTAL_W = 12;
	localparam int KEY_W       = 128;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MAX_TOTAL_W-1:0] MAX_TOTAL_RST = 12'd2064;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic        func;
		logic [63:0] entry_time;
		logic [63:0] entry_id;
		logic [63:0] balance_high;
		logic [63:0] balance_low;
	} sched_in_t;

	typedef struct packed {
		logic                   head_valid;
		logic [63:0]            head_id;
		logic [63:0]            head_time;
		logic [BKT_IDX_W-1:0]   head_bucket;
		logic [TOTAL_W-1:0]     total_entries;
		logic                   evicted;
		logic                   error;
	} sched_out_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic                 func;
		logic [63:0]          entry_time;
		logic [63:0]          entry_id;
		logic [BKT_IDX_W-1:0] bucket;
	} op_t;

endpackage
`default_nettype wire

### src/bbrr_front.sv
`default_nettype none
module bbrr_front import bbrr_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire sched_in_t cmd,
	output logic           busy,
	output logic           op_valid,
	output op_t            op,
	input  wire logic      op_ready
);

	localparam logic [BKT_IDX_W-1:0] LAST_BKT = BKT_IDX_W'(BUCKETS - 1);

	logic                 hold_q;
	logic                 found_q;
	logic [2:0]           chunk_q;
	sched_in_t            cmd_q;
	logic [BKT_IDX_W-1:0] bkt_q;

	logic [127:0]         bal;
	logic [15:0]          slice;
	logic [4:0]           lead;
	logic [BKT_IDX_W-1:0] blen;
	logic [BKT_IDX_W-1:0] bsat;

	// one 16-bit slice of the balance per cycle, from the top
	assign bal   = {cmd_q.balance_high, cmd_q.balance_low};
	assign slice = bal[{chunk_q, 4'b0000} +: 16];

	always_comb begin
		lead = '0;
		for (int i = 0; i < 16; i++) begin
			if (slice[i]) begin
				lead = 5'(i + 1);
			end
		end
	end

	assign blen = {1'b0, chunk_q, 4'b0000} + {3'b000, lead};
	assign bsat = (blen > LAST_BKT) ? LAST_BKT : blen;

	// hold register and classifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			found_q <= 1'b0;
			chunk_q <= '0;
		end else if (start && !hold_q) begin
			hold_q  <= 1'b1;
			found_q <= (cmd.func == FUNC_POP);
			chunk_q <= 3'd7;
		end else if (hold_q && !found_q) begin
			if (slice != '0 || chunk_q == 3'd0) begin
				found_q <= 1'b1;
			end else begin
				chunk_q <= chunk_q - 3'd1;
			end
		end else if (op_valid && op_ready) begin
			hold_q <= 1'b0;
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (start && !hold_q) begin
			cmd_q <= cmd;
		end
		if (hold_q && !found_q) begin
			bkt_q <= bsat;
		end
	end

	assign busy          = hold_q;
	assign op_valid      = hold_q && found_q;
	assign op.func       = cmd_q.func;
	assign op.entry_time = cmd_q.entry_time;
	assign op.entry_id   = cmd_q.entry_id;
	assign op.bucket     = bkt_q;

endmodule
`default_nettype wire

### src/bbrr_queue.sv
`default_nettype none
module bbrr_queue import bbrr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire op_t  in_op,
	output logic      out_valid,
	input  wire logic out_ready,
	output op_t       out_op
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != CW'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = ent_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_op;
		end
	end

endmodule
`default_nettype wire

### src/bbrr_back.sv
`default_nettype none
module bbrr_back import bbrr_pkg::*; #(
	parameter int BUCKETS      = BUCKETS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [MAX_TOTAL_W-1:0] cfg_data,
	input  wire logic                   op_valid,
	input  wire op_t                    op,
	output logic                        op_ready,
	output logic                        done,
	output sched_out_t                  result
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int FW    = $clog2(BUCKET_DEPTH + 1);
	localparam int TW    = $clog2(BUCKETS * BUCKET_DEPTH + 1);
	localparam int AW    = BW + SW;
	localparam int LANES = 4;

	localparam logic [FW:0]   DEPTH_X  = (FW + 1)'(BUCKET_DEPTH);
	localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SCAN    = 4'd1;
	localparam logic [3:0] ST_TAIL    = 4'd2;
	localparam logic [3:0] ST_PUSHFIN = 4'd3;
	localparam logic [3:0] ST_PSHIFT  = 4'd4;
	localparam logic [3:0] ST_POPFIN  = 4'd5;
	localparam logic [3:0] ST_SEEK    = 4'd6;
	localparam logic [3:0] ST_HEAD    = 4'd7;
	localparam logic [3:0] ST_HEADRD  = 4'd8;
	localparam logic [3:0] ST_FILL    = 4'd9;

	function automatic logic [BW-1:0] bkt_inc(input logic [BW-1:0] v);
		return (v == LAST_BKT) ? '0 : v + 1'b1;
	endfunction

	// slot memory, {time, id} per slot, rows by bucket
	logic [KEY_W-1:0] mem [2**AW];
	logic [KEY_W-1:0] rdata_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;

	// fill count memory, guarded by a non-empty bit per bucket
	logic [FW-1:0]      fill_mem [BUCKETS];
	logic [FW-1:0]      fill_rd_q;
	logic [BUCKETS-1:0] nz_q;
	logic               fill_we;
	logic [FW-1:0]      fill_wd;
	logic [BW-1:0]      fill_ra;
	logic [FW-1:0]      fill_now;

	logic [3:0]             st_q;
	logic [BW-1:0]          cur_q;
	logic [TW-1:0]          total_q;
	logic [MAX_TOTAL_W-1:0] max_total_q;
	logic                   func_q;
	logic [BW-1:0]          b_q;
	logic [KEY_W-1:0]       key_q;
	logic [KEY_W-1:0]       carry_q;
	logic [FW-1:0]          fill_cur_q;
	logic [FW-1:0]          j_q;
	logic                   ins_q;
	logic                   dup_q;
	logic                   evict_q;
	logic                   err_q;
	logic                   empty_on_entry_q;
	logic [BW-1:0]          scan_pos_q;
	logic                   done_q;
	sched_out_t             result_q;

	logic [BW-1:0] op_b;
	logic [FW:0]   j_p1;
	logic [FW:0]   j_p2;
	logic [FW:0]   fill_x;
	logic          key_gt;
	logic          key_eq;
	logic [FW-1:0] cap;
	logic [FW:0]   push_nf;
	logic          push_ev;
	logic          seek_hit;
	logic [BW-1:0] seek_idx;
	logic [BW-1:0] seek_next;

	assign op_b     = op.bucket[BW-1:0];
	assign j_p1     = {1'b0, j_q} + 1'b1;
	assign j_p2     = {1'b0, j_q} + 2'd2;
	assign fill_x   = {1'b0, fill_cur_q};
	assign key_gt   = rdata_q > key_q;
	assign key_eq   = rdata_q == key_q;
	assign fill_ra  = (op.func == FUNC_PUSH) ? op_b : cur_q;
	assign fill_now = nz_q[b_q] ? fill_rd_q : '0;

	// per-bucket cap: min(depth, max(1, max_total / BUCKETS))
	always_comb begin
		logic [FW-1:0] cnt;
		cnt = '0;
		for (int k = 1; k <= BUCKET_DEPTH; k++) begin
			if ({2'b00, max_total_q} >= 14'(k * BUCKETS)) begin
				cnt = FW'(k);
			end
		end
		cap = (cnt == '0) ? FW'(1) : cnt;
	end

	// new fill after a push, with overflow trim
	always_comb begin
		push_nf = fill_x + (dup_q ? (FW + 1)'(0) : (FW + 1)'(1));
		push_ev = push_nf > {1'b0, cap};
		if (push_ev) begin
			push_nf = push_nf - 1'b1;
		end
	end

	// round-robin seek, several buckets per cycle
	always_comb begin
		logic [BW-1:0] p;
		p         = scan_pos_q;
		seek_hit  = 1'b0;
		seek_idx  = '0;
		for (int k = 0; k < LANES; k++) begin
			p = bkt_inc(p);
			if (!seek_hit && nz_q[p]) begin
				seek_hit = 1'b1;
				seek_idx = p;
			end
		end
		seek_next = p;
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {b_q, j_p1[SW-1:0]};
		wr_en   = 1'b0;
		wr_addr = {b_q, j_q[SW-1:0]};
		wr_data = key_q;
		case (st_q)
			ST_FILL: begin
				if (func_q == FUNC_PUSH) begin
					rd_en   = (fill_now != '0);
					rd_addr = {b_q, SW'(0)};
				end else begin
					rd_en   = (fill_now > FW'(1));
					rd_addr = {b_q, SW'(1)};
				end
			end
			ST_SCAN: begin
				rd_en = j_p1 < fill_x;
				if (!ins_q) begin
					wr_en = key_gt;
				end else begin
					wr_en   = 1'b1;
					wr_data = carry_q;
				end
			end
			ST_TAIL: begin
				wr_en   = fill_x < DEPTH_X;
				wr_addr = {b_q, fill_cur_q[SW-1:0]};
				wr_data = ins_q ? carry_q : key_q;
			end
			ST_PSHIFT: begin
				wr_en   = 1'b1;
				wr_data = rdata_q;
				rd_en   = j_p2 < fill_x;
				rd_addr = {b_q, j_p2[SW-1:0]};
			end
			ST_HEAD: begin
				rd_en   = (total_q != '0);
				rd_addr = {cur_q, SW'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// fill count update for the bucket in hand
	assign fill_we = (st_q == ST_PUSHFIN) || (st_q == ST_POPFIN);
	assign fill_wd = (st_q == ST_PUSHFIN) ? push_nf[FW-1:0] : fill_cur_q - 1'b1;

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[b_q] <= fill_wd;
		end
		if (st_q == ST_IDLE && op_valid) begin
			fill_rd_q <= fill_mem[fill_ra];
		end
	end

	assign op_ready = (st_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cur_q       <= '0;
			total_q     <= '0;
			max_total_q <= MAX_TOTAL_RST;
			done_q      <= 1'b0;
			nz_q        <= '0;
		end else begin
			done_q <= (st_q == ST_HEADRD) || (st_q == ST_HEAD && total_q == '0);
			if (cfg_we) begin
				max_total_q <= cfg_data;
			end
			case (st_q)
				ST_IDLE: begin
					if (op_valid) begin
						st_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (func_q == FUNC_PUSH) begin
						st_q <= (fill_now == '0) ? ST_TAIL : ST_SCAN;
					end else if (fill_now == '0) begin
						st_q <= ST_HEAD;
					end else if (fill_now > FW'(1)) begin
						st_q <= ST_PSHIFT;
					end else begin
						st_q <= ST_POPFIN;
					end
				end
				ST_SCAN: begin
					if (!ins_q && key_eq) begin
						st_q <= ST_PUSHFIN;
					end else if (j_p1 == fill_x) begin
						st_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					st_q <= ST_PUSHFIN;
				end
				ST_PUSHFIN: begin
					nz_q[b_q] <= 1'b1;
					if (!dup_q && !push_ev) begin
						total_q <= total_q + 1'b1;
					end else if (dup_q && push_ev) begin
						total_q <= total_q - 1'b1;
					end
					if (empty_on_entry_q) begin
						cur_q <= b_q;
					end
					st_q <= ST_HEAD;
				end
				ST_PSHIFT: begin
					if (j_p2 == fill_x) begin
						st_q <= ST_POPFIN;
					end
				end
				ST_POPFIN: begin
					nz_q[b_q] <= (fill_cur_q > FW'(1));
					total_q   <= total_q - 1'b1;
					if (total_q == TW'(1)) begin
						cur_q <= bkt_inc(b_q);
						st_q  <= ST_HEAD;
					end else begin
						st_q <= ST_SEEK;
					end
				end
				ST_SEEK: begin
					if (seek_hit) begin
						cur_q <= seek_idx;
						st_q  <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (total_q != '0) begin
						st_q <= ST_HEADRD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_HEADRD: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current operation
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (op_valid) begin
					key_q            <= {op.entry_time, op.entry_id};
					j_q              <= '0;
					ins_q            <= 1'b0;
					dup_q            <= 1'b0;
					evict_q          <= 1'b0;
					empty_on_entry_q <= (total_q == '0);
					func_q           <= op.func;
					b_q              <= fill_ra;
				end
			end
			ST_FILL: begin
				fill_cur_q <= fill_now;
				err_q      <= (func_q == FUNC_POP) && (fill_now == '0);
			end
			ST_SCAN: begin
				if (!ins_q) begin
					if (key_eq) begin
						dup_q <= 1'b1;
					end else if (key_gt) begin
						ins_q   <= 1'b1;
						carry_q <= rdata_q;
					end
				end else begin
					carry_q <= rdata_q;
				end
				j_q <= j_p1[FW-1:0];
			end
			ST_PUSHFIN: begin
				evict_q <= push_ev;
			end
			ST_PSHIFT: begin
				j_q <= j_p1[FW-1:0];
			end
			ST_POPFIN: begin
				scan_pos_q <= b_q;
			end
			ST_SEEK: begin
				scan_pos_q <= seek_next;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (st_q == ST_HEAD || st_q == ST_HEADRD) begin
			result_q.head_valid    <= (total_q != '0);
			result_q.head_id       <= (st_q == ST_HEADRD) ? rdata_q[63:0] : 64'd0;
			result_q.head_time     <= (st_q == ST_HEADRD) ? rdata_q[127:64] : 64'd0;
			result_q.head_bucket   <= BKT_IDX_W'(cur_q);
			result_q.total_entries <= TOTAL_W'(total_q);
			result_q.evicted       <= evict_q;
			result_q.error         <= err_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### src/balance_bucket_round_robin_scheduler.sv
`default_nettype none
// Balance-bucket round-robin scheduler. A command is taken when start is high
// and busy is low; each command gives exactly one result beat, shown for one
// cycle with done high, which the receiver must take as it comes. The front
// classifies a push by the bit length of its balance, one 16-bit slice per
// cycle from the top (no slice for a pop), offers it in the next cycle to a
// two-entry queue and keeps busy high until the queue takes it; the back picks
// it up from the queue when idle. The back reads the bucket fill count, then
// works through the slot memory one slot per cycle: a push ends early on a
// duplicate key, a pop that leaves entries seeks the next non-empty bucket
// four buckets at a step, and done is registered once the new head is known.
module balance_bucket_round_robin_scheduler import bbrr_pkg::*; #(
	parameter int BUCKETS      = BUCKETS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire sched_in_t              cmd,
	output logic                        done,
	output sched_out_t                  result,
	input  wire logic                   cfg_we,
	input  wire logic [MAX_TOTAL_W-1:0] cfg_data
);

	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	// classify commands
	bbrr_front #(
		.BUCKETS (BUCKETS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.op_valid (f_valid),
		.op       (f_op),
		.op_ready (f_ready)
	);

	// decoupling queue
	bbrr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_op    (b_op)
	);

	// execute against bucket storage
	bbrr_back #(
		.BUCKETS      (BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.op_valid (b_valid),
		.op       (b_op),
		.op_ready (b_ready),
		.done     (done),
		.result   (result)
	);

endmodule
`default_nettype wire

### test/bbrr_checker.sv
`default_nettype none
module bbrr_checker import bbrr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   busy,
	input  wire sched_in_t              cmd,
	input  wire logic                   done,
	input  wire sched_out_t             result,
	input  wire logic                   cfg_we,
	input  wire logic [MAX_TOTAL_W-1:0] cfg_data,
	output int                          fail_count,
	output int                          pending,
	output int                          evict_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = BUCKETS_DEF;
	localparam int DEPTH = BUCKET_DEPTH_DEF;

	// shadow copy of the scheduler state
	logic [63:0] q_time [NB][DEPTH+1];
	logic [63:0] q_id [NB][DEPTH+1];
	int unsigned q_fill [NB];
	int unsigned cur_bkt;
	int unsigned budget;

	sched_out_t expected_beats[$];

	function automatic int unsigned bit_length(logic [63:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic int unsigned held_total();
		int unsigned s;
		s = 0;
		for (int i = 0; i < NB; i++) s += q_fill[i];
		return s;
	endfunction

	function automatic int unsigned bucket_limit();
		int unsigned c;
		c = budget / NB;
		if (c < 1) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// round-robin move to the next non-empty bucket
	task automatic next_bucket();
		cur_bkt = (cur_bkt + 1) % NB;
		for (int i = 0; q_fill[cur_bkt] == 0 && i < NB; i++)
			cur_bkt = (cur_bkt + 1) % NB;
	endtask

	// apply one command to the shadow state and form its result beat
	task automatic schedule_step(input sched_in_t c, output sched_out_t r);
		int unsigned b, f, p, tot;
		logic none_held, dup;
		r = '0;
		if (c.func == FUNC_PUSH) begin
			none_held = (held_total() == 0);
			b = (c.balance_high != 0) ? 64 + bit_length(c.balance_high)
				: bit_length(c.balance_low);
			if (b > NB - 1) b = NB - 1;
			f = q_fill[b];
			if (f > DEPTH) f = DEPTH;
			dup = 1'b0;
			for (p = 0; p < f; p++) begin
				if (q_time[b][p] > c.entry_time ||
					(q_time[b][p] == c.entry_time && q_id[b][p] >= c.entry_id)) begin
					dup = (q_time[b][p] == c.entry_time && q_id[b][p] == c.entry_id);
					break;
				end
			end
			if (!dup) begin
				for (int k = f; k > p; k--) begin
					q_time[b][k] = q_time[b][k-1];
					q_id[b][k] = q_id[b][k-1];
				end
				q_time[b][p] = c.entry_time;
				q_id[b][p] = c.entry_id;
				f++;
			end
			if (f > bucket_limit()) begin
				f--;
				r.evicted = 1'b1;
			end
			q_fill[b] = f;
			if (none_held) next_bucket();
		end else begin
			f = q_fill[cur_bkt];
			if (f == 0) begin
				r.error = 1'b1;
			end else begin
				for (int k = 0; k + 1 < f; k++) begin
					q_time[cur_bkt][k] = q_time[cur_bkt][k+1];
					q_id[cur_bkt][k] = q_id[cur_bkt][k+1];
				end
				q_fill[cur_bkt] = f - 1;
				next_bucket();
			end
		end
		tot = held_total();
		if (tot != 0 && q_fill[cur_bkt] != 0) begin
			r.head_valid = 1'b1;
			r.head_id = q_id[cur_bkt][0];
			r.head_time = q_time[cur_bkt][0];
		end
		r.head_bucket = cur_bkt[BKT_IDX_W-1:0];
		r.total_entries = tot[TOTAL_W-1:0];
	endtask

	// observe commands, config writes and result beats
	always @(posedge clk or negedge arst_n) begin
		sched_out_t exp_beat;
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) q_fill[i] = 0;
			cur_bkt = 0;
			budget = MAX_TOTAL_RST;
			expected_beats.delete();
			fail_count <= 0;
			pending <= 0;
			evict_seen <= 0;
		end else begin
			if (cfg_we) budget = cfg_data;
			if (start && !busy) begin
				schedule_step(cmd, exp_beat);
				expected_beats = {expected_beats, exp_beat};
			end
			if (done) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with no command outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_beat = expected_beats.pop_front();
					if (result !== exp_beat) begin
						fail_count <= fail_count + 1;
						if (result.head_valid !== exp_beat.head_valid)
							$error("head_valid expected %0d actual %0d",
								exp_beat.head_valid, result.head_valid);
						if (result.head_id !== exp_beat.head_id)
							$error("head_id expected %h actual %h",
								exp_beat.head_id, result.head_id);
						if (result.head_time !== exp_beat.head_time)
							$error("head_time expected %h actual %h",
								exp_beat.head_time, result.head_time);
						if (result.head_bucket !== exp_beat.head_bucket)
							$error("head_bucket expected %0d actual %0d",
								exp_beat.head_bucket, result.head_bucket);
						if (result.total_entries !== exp_beat.total_entries)
							$error("total_entries expected %0d actual %0d",
								exp_beat.total_entries, result.total_entries);
						if (result.evicted !== exp_beat.evicted)
							$error("evicted expected %0d actual %0d",
								exp_beat.evicted, result.evicted);
						if (result.error !== exp_beat.error)
							$error("error expected %0d actual %0d",
								exp_beat.error, result.error);
					end
					if (exp_beat.evicted) evict_seen <= evict_seen + 1;
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
	import bbrr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sched_in_t cmd = '0;
	logic done;
	sched_out_t result;
	logic cfg_we = 1'b0;
	logic [MAX_TOTAL_W-1:0] cfg_data = '0;
	int fail_count, pending, evict_seen;
	int cycles = 0;
	int n_push = 0, n_pop = 0;
	logic idle_on = 1'b1;

	balance_bucket_round_robin_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	bbrr_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .evict_seen(evict_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("balance_bucket_round_robin_scheduler verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// balance whose bit length lands in bucket b
	function automatic sched_in_t push_cmd(int b, logic [63:0] t, logic [63:0] id);
		sched_in_t c;
		c = '0;
		c.func = FUNC_PUSH;
		c.entry_time = t;
		c.entry_id = id;
		if (b == 0) begin
			c.balance_low = '0;
		end else if (b <= 64) begin
			c.balance_low = (rand64() & ((64'd1 << (b - 1)) - 64'd1)) | (64'd1 << (b - 1));
		end else begin
			c.balance_high = (rand64() & ((64'd1 << (b - 65)) - 64'd1))
				| (64'd1 << (b - 65));
			c.balance_low = rand64();
		end
		return c;
	endfunction

	function automatic sched_in_t pop_cmd();
		sched_in_t c;
		c.func = FUNC_POP;
		c.entry_time = rand64();
		c.entry_id = rand64();
		c.balance_high = rand64();
		c.balance_low = rand64();
		return c;
	endfunction

	// one command beat, sometimes followed by a random gap
	task automatic send(sched_in_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (c.func == FUNC_PUSH) n_push++;
		else n_pop++;
		if (idle_on && $urandom_range(0, 99) < 36) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_budget(logic [MAX_TOTAL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic sched_in_t random_cmd();
		int hot[8] = '{0, 1, 2, 63, 64, 65, 127, 128};
		int b;
		logic [63:0] t, id;
		if ($urandom_range(0, 99) < 40) return pop_cmd();
		b = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, 7)] : $urandom_range(0, 128);
		t = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 7)) : rand64();
		id = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 3)) : rand64();
		return push_cmd(b, t, id);
	endfunction

	initial begin
		logic [MAX_TOTAL_W-1:0] budgets[7];
		budgets = '{12'd2064, 12'd0, 12'd4095, 12'd258, 12'd129, 12'd1000, 12'd2064};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes of keys and buckets, ties, duplicates
		send(pop_cmd());
		send(push_cmd(0, 64'd0, 64'd0));
		send(push_cmd(0, 64'd0, 64'd0));
		send(push_cmd(0, 64'd0, '1));
		send(push_cmd(0, '1, '1));
		send(push_cmd(0, '1, 64'd5));
		send(push_cmd(1, 64'd7, 64'd7));
		send(push_cmd(64, '1, 64'd1));
		send(push_cmd(65, 64'd3, 64'd2));
		send(push_cmd(128, 64'd0, '1));
		send(push_cmd(128, '1, 64'd0));
		for (int i = 0; i < 10; i++) send(pop_cmd());
		send(pop_cmd());
		drain();

		// random phases at several bucket caps
		for (int ph = 0; ph < 7; ph++) begin
			write_budget(budgets[ph]);
			for (int i = 0; i < 190; i++) begin
				idle_on = !(ph == 2 && i < 120);
				send(random_cmd());
			end
			drain();
		end

		repeat (30) @(posedge clk);
		$display("covered %0d pushes and %0d pops over 7 cap settings, %0d evictions",
			n_push, n_pop, evict_seen);
		if (fail_count == 0 && pending == 0)
			$display("balance_bucket_round_robin_scheduler verification clean");
		else
			$display("balance_bucket_round_robin_scheduler verification failed");
		$finish;
	end

endmodule
`default_nettype wire
